/* rtl/stq_pkg.sv */
// stq_pkg: shared types and constants of the sorted timeout queue
// depends on nothing; used by rtl/sorted_timeout_queue.sv
package stq_pkg;

  localparam int unsigned DefCapacity = 32;
  localparam int unsigned DefTimeBits = 32;
  localparam int unsigned MaxResults  = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_ADJUST = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_NONE    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_DECIDE,
    S_REM_RD,
    S_REM_WR,
    S_INS_RD,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_TK_RD,
    S_TK_CHK,
    S_TK_END,
    S_RESP
  } state_e;

endpackage

/* rtl/sorted_timeout_queue.sv */
// sorted_timeout_queue: timers kept sorted by expiry in one synchronous memory
// depends on stq_pkg (rtl/stq_pkg.sv)
//
//  channel  | dir | tdata (low bit up)                          | side band
//  ---------+-----+---------------------------------------------+----------------------
//  s_axis   | in  | command[1:0] timer_id[9:2] time_value[41:10] | none
//  m_axis   | out | expired_id[7:0] status[9:8]                 | tuser kind, tlast last
//
//  steps: each memory step is a read state then a check or write state, so
//  add/delete/adjust walk the list to find the slot and then move entries, with
//  the queue length as the move distance; a tick removes expired timers in turn
//  because every expiry shifts the list down, one memory access at a time
//  reset: occupied count and control clear at once, memory contents are not
//  cleared and are only read below the occupied count
//  stalls: one command at a time; a held result on m_axis stalls the sequencer
//  only when the next result is ready to be pushed
module sorted_timeout_queue #(
  parameter int unsigned CAPACITY  = stq_pkg::DefCapacity,
  parameter int unsigned TIME_BITS = stq_pkg::DefTimeBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // command[1:0] timer_id[9:2] time_value[41:10]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // expired_id[7:0] status[9:8]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o
);

  localparam int unsigned StW   = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned EW    = StW + 8;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned NW    = $clog2(stq_pkg::MaxResults + 1);

  // timer memory: {expiry, id} per slot, slots kept in sorted order
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rdata_q;
  logic              rd_en, wr_en;
  logic [AddrW-1:0]  rd_addr, wr_addr;
  logic [EW-1:0]     wr_data;

  stq_pkg::state_e state_q, state_d;
  stq_pkg::cmd_e   cmd_q, cmd_d;
  stq_pkg::status_e status_q, status_d;
  logic [7:0]      id_q, id_d;
  logic [StW-1:0]  t_q, t_d;
  logic [CntW-1:0] idx_q, idx_d, pos_q, pos_d, count_q, count_d;
  logic [NW-1:0]   n_q, n_d;
  logic            found_q, found_d;
  logic            pend_q, pend_d;
  logic [7:0]      pend_id_q, pend_id_d;

  // output register
  logic            out_valid_q, out_valid_d;
  stq_pkg::kind_e  out_kind_q, out_kind_d;
  logic [7:0]      out_id_q, out_id_d;
  stq_pkg::status_e out_status_q, out_status_d;
  logic            out_last_q, out_last_d;

  logic            in_acc, out_free, due, full, id_hit;
  logic [CntW-1:0] idx_inc;
  logic [StW-1:0]  rd_exp;
  logic [7:0]      rd_id;

  assign s_axis_tready_o = (state_q == stq_pkg::S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rd_exp   = rdata_q[EW-1:8];
  assign rd_id    = rdata_q[7:0];
  assign due      = (rd_exp <= t_q);
  assign id_hit   = (rd_id == id_q);
  assign full     = (count_q == CntW'(CAPACITY));
  assign idx_inc  = idx_q + CntW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (stq_pkg::cmd_e'(s_axis_tdata_i[1:0]) == stq_pkg::CMD_TICK)
                    ? stq_pkg::S_TK_RD : stq_pkg::S_FIND_RD;
        end
      end
      stq_pkg::S_FIND_RD:  state_d = (idx_q == count_q) ? stq_pkg::S_DECIDE
                                                         : stq_pkg::S_FIND_CHK;
      stq_pkg::S_FIND_CHK: state_d = id_hit ? stq_pkg::S_DECIDE : stq_pkg::S_FIND_RD;
      stq_pkg::S_DECIDE: begin
        if (cmd_q == stq_pkg::CMD_ADD) begin
          state_d = (found_q || full) ? stq_pkg::S_RESP : stq_pkg::S_INS_RD;
        end else begin
          state_d = found_q ? stq_pkg::S_REM_RD : stq_pkg::S_RESP;
        end
      end
      stq_pkg::S_REM_RD: begin
        if (idx_inc < count_q) begin
          state_d = stq_pkg::S_REM_WR;
        end else if (cmd_q == stq_pkg::CMD_TICK) begin
          state_d = stq_pkg::S_TK_RD;
        end else if (cmd_q == stq_pkg::CMD_ADJUST) begin
          state_d = stq_pkg::S_INS_RD;
        end else begin
          state_d = stq_pkg::S_RESP;
        end
      end
      stq_pkg::S_REM_WR:  state_d = stq_pkg::S_REM_RD;
      stq_pkg::S_INS_RD:  state_d = (idx_q == count_q) ? stq_pkg::S_SH_RD
                                                        : stq_pkg::S_INS_CHK;
      stq_pkg::S_INS_CHK: state_d = due ? stq_pkg::S_INS_RD : stq_pkg::S_SH_RD;
      stq_pkg::S_SH_RD:   state_d = (idx_q == pos_q) ? stq_pkg::S_RESP
                                                      : stq_pkg::S_SH_WR;
      stq_pkg::S_SH_WR:   state_d = stq_pkg::S_SH_RD;
      stq_pkg::S_TK_RD: begin
        state_d = ((n_q == NW'(stq_pkg::MaxResults)) || (count_q == '0))
                  ? stq_pkg::S_TK_END : stq_pkg::S_TK_CHK;
      end
      stq_pkg::S_TK_CHK: begin
        if (!due) begin
          state_d = stq_pkg::S_TK_END;
        end else if (!pend_q || out_free) begin
          state_d = stq_pkg::S_REM_RD;
        end
      end
      stq_pkg::S_TK_END,
      stq_pkg::S_RESP: begin
        if (out_free) state_d = stq_pkg::S_IDLE;
      end
      default: state_d = stq_pkg::S_IDLE;
    endcase
  end

  // datapath, memory controls and result pushes
  always_comb begin
    cmd_d = cmd_q; id_d = id_q; t_d = t_q; idx_d = idx_q; pos_d = pos_q;
    count_d = count_q; n_d = n_q; found_d = found_q; status_d = status_q;
    pend_d = pend_q; pend_id_d = pend_id_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = rdata_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    case (state_q)
      stq_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_d    = stq_pkg::cmd_e'(s_axis_tdata_i[1:0]);
          id_d     = s_axis_tdata_i[9:2];
          t_d      = s_axis_tdata_i[10 +: StW];
          idx_d    = '0;
          n_d      = '0;
          found_d  = 1'b0;
          pend_d   = 1'b0;
          status_d = stq_pkg::ST_OK;
        end
      end
      stq_pkg::S_FIND_RD: begin
        if (idx_q != count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[AddrW-1:0];
        end
      end
      stq_pkg::S_FIND_CHK: begin
        if (id_hit) begin
          found_d = 1'b1;
          pos_d   = idx_q;
        end else begin
          idx_d = idx_inc;
        end
      end
      stq_pkg::S_DECIDE: begin
        if (cmd_q == stq_pkg::CMD_ADD) begin
          if (found_q)   status_d = stq_pkg::ST_DUPLICATE;
          else if (full) status_d = stq_pkg::ST_FULL;
          idx_d = '0;
        end else begin
          if (!found_q) status_d = stq_pkg::ST_NOT_FOUND;
          idx_d = pos_q;
        end
      end
      stq_pkg::S_REM_RD: begin
        if (idx_inc < count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AddrW-1:0];
        end else begin
          count_d = count_q - CntW'(1);
          idx_d   = '0;
        end
      end
      stq_pkg::S_REM_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AddrW-1:0];
        idx_d   = idx_inc;
      end
      stq_pkg::S_INS_RD: begin
        if (idx_q != count_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[AddrW-1:0];
        end else begin
          pos_d = idx_q;
        end
      end
      stq_pkg::S_INS_CHK: begin
        if (due) begin
          idx_d = idx_inc;
        end else begin
          pos_d = idx_q;
          idx_d = count_q;
        end
      end
      stq_pkg::S_SH_RD: begin
        if (idx_q == pos_q) begin
          wr_en   = 1'b1;
          wr_addr = pos_q[AddrW-1:0];
          wr_data = {t_q, id_q};
          count_d = count_q + CntW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q[AddrW-1:0] - AddrW'(1);
        end
      end
      stq_pkg::S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[AddrW-1:0];
        idx_d   = idx_q - CntW'(1);
      end
      stq_pkg::S_TK_RD: begin
        if ((n_q != NW'(stq_pkg::MaxResults)) && (count_q != '0)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      stq_pkg::S_TK_CHK: begin
        if (due && (!pend_q || out_free)) begin
          if (pend_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = stq_pkg::KIND_EXPIRED;
            out_id_d     = pend_id_q;
            out_status_d = stq_pkg::ST_OK;
            out_last_d   = 1'b0;
          end
          pend_d    = 1'b1;
          pend_id_d = rd_id;
          n_d       = n_q + NW'(1);
          idx_d     = '0;
        end
      end
      stq_pkg::S_TK_END: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = pend_q ? stq_pkg::KIND_EXPIRED : stq_pkg::KIND_NONE;
          out_id_d     = pend_q ? pend_id_q : 8'd0;
          out_status_d = stq_pkg::ST_OK;
          out_last_d   = 1'b1;
          pend_d       = 1'b0;
        end
      end
      stq_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = stq_pkg::KIND_ACK;
          out_id_d     = 8'd0;
          out_status_d = status_q;
          out_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory: read and write never share a cycle, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stq_pkg::S_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    id_q         <= id_d;
    t_q          <= t_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    n_q          <= n_d;
    found_q      <= found_d;
    status_q     <= status_d;
    pend_id_q    <= pend_id_d;
    out_kind_q   <= out_kind_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_status_q, out_id_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // occupancy never exceeds the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("occupied count above capacity");

  // an expired timer or an empty tick always carries ok status
  a_tick_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != stq_pkg::KIND_ACK)) |-> (out_status_q == stq_pkg::ST_OK))
    else $error("tick result with error status");

  // memory reads and writes never collide in one cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en))
    else $error("memory read and write in the same cycle");

  // an accepted command always leaves the idle state
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != stq_pkg::S_IDLE))
    else $error("command accepted without starting work");

endmodule
